### src/sdt_pkg.sv
package sdt_pkg;

  localparam int MAX_TRACKS_D     = 16;
  localparam int MAX_DETECTIONS_D = 16;
  localparam int COORD_BITS_D     = 12;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 12;

  localparam logic [CFG_IDX_W-1:0] REG_TOL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INIT = 3'd4;

  localparam logic [11:0] TOL_RST  = 12'd50;
  localparam logic [5:0]  HIT_RST  = 6'd5;
  localparam logic [5:0]  MAX_RST  = 6'd40;
  localparam logic [5:0]  VIS_RST  = 6'd15;
  localparam logic [5:0]  INIT_RST = 6'd5;

  localparam logic OP_DET = 1'b0;
  localparam logic OP_EOF = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [11:0] det_x;
    logic [11:0] det_y;
    logic [9:0]  det_size;
  } in_item_t;

  typedef struct packed {
    logic [11:0] out_x;
    logic [11:0] out_y;
    logic [9:0]  out_size;
    logic [5:0]  out_score;
    logic        any_visible;
    logic        is_last;
    logic        overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRK,
    ST_DET,
    ST_TEND,
    ST_SHIFT,
    ST_NEW,
    ST_REP,
    ST_REPW,
    ST_EMPTY
  } state_t;

endpackage

### src/sdt_near.sv
module sdt_near (
  input  logic [11:0] a,
  input  logic [11:0] b,
  input  logic [11:0] tol,
  output logic        near
);
  logic [11:0] d;
  always_comb begin
    d = (a > b) ? (a - b) : (b - a);
    near = (d <= tol);
  end
endmodule

### src/scored_detection_tracker.sv
// Scored detection tracker.
// Input channel (in_valid/in_ready/in_data): opcode 0 stores a detection in
// the frame buffer (no result); opcode 1 ends the frame and runs the update.
// After each accepted detection in_ready drops for a single cycle. An
// end-of-frame update steps one track against one buffered detection per
// cycle through two distance comparators, one per axis, shared by all pairs
// in a match scan over all tracks and buffered detections; each removed
// track is closed up by moving the later entries down one by one. Leftover
// detections are then appended as new tracks, and the report walks the
// table up to the last visible track, or sends one empty result.
// Results leave through out_valid/out_ready/out_data; each result is held
// in the output register until its transfer, so a stalled receiver simply
// stretches the report and the block stays busy until the last transfer.
// in_ready is low throughout the update and the report.
// Reset (rst_n low, synchronous) clears counts, consumed marks, the drop
// flag and registers to their reset values; table contents stay undefined.
// Configuration writes (cfg_we/cfg_index/cfg_data) take effect at once; the
// user must issue them only while the block is idle; the block does not enforce this.
module scored_detection_tracker #(
  parameter int MAX_TRACKS     = sdt_pkg::MAX_TRACKS_D,
  parameter int MAX_DETECTIONS = sdt_pkg::MAX_DETECTIONS_D,
  parameter int COORD_BITS     = sdt_pkg::COORD_BITS_D
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  sdt_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output sdt_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [sdt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sdt_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import sdt_pkg::*;

  localparam int TW = $clog2(MAX_TRACKS + 1);
  localparam int DW = $clog2(MAX_DETECTIONS + 1);
  localparam int TI = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int DI = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
  localparam logic [11:0] CMASK = 12'((1 << COORD_BITS) - 1);

  // registers
  logic [11:0] tol_r;
  logic [5:0]  hit_r, max_r, vis_r, init_r;

  // tables (small, read at sequencer-chosen indices one per cycle)
  logic [11:0] tx_r [MAX_TRACKS];
  logic [11:0] ty_r [MAX_TRACKS];
  logic [9:0]  ts_r [MAX_TRACKS];
  logic [5:0]  tsc_r [MAX_TRACKS];
  logic        tvis_r [MAX_TRACKS];
  logic [11:0] dx_r [MAX_DETECTIONS];
  logic [11:0] dy_r [MAX_DETECTIONS];
  logic [9:0]  dsz_r [MAX_DETECTIONS];
  logic [MAX_DETECTIONS-1:0] used_r;

  logic [TW-1:0] tcnt_r, ti_r, tj_r;
  logic [DW-1:0] dcnt_r, di_r;
  logic          drop_r, hitf_r, stall_r;
  logic          anyv_r;
  logic [TW-1:0] nvis_r, left_r;
  state_t        st_r, st_nxt;
  out_item_t     od_r;
  logic          ov_r;

  // working copy of the current track
  logic [11:0] cx_r, cy_r;
  logic [9:0]  cs_r;
  logic [5:0]  csc_r;

  logic nx, ny;
  sdt_near u_nx (.a(cx_r), .b(dx_r[di_r[DI-1:0]]), .tol(tol_r), .near(nx));
  sdt_near u_ny (.a(cy_r), .b(dy_r[di_r[DI-1:0]]), .tol(tol_r), .near(ny));

  logic [6:0] sum;
  assign sum = {1'b0, csc_r} + {1'b0, hit_r};

  assign in_ready  = (st_r == ST_IDLE) && !stall_r;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else        st_r <= st_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (in_valid && in_ready && in_data.opcode == OP_EOF) st_nxt = ST_TRK;
      ST_TRK: begin
        if (ti_r >= tcnt_r) st_nxt = ST_NEW;
        else                st_nxt = ST_DET;
      end
      ST_DET: if (di_r >= dcnt_r) st_nxt = ST_TEND;
      ST_TEND: begin
        if (!hitf_r && csc_r <= 6'd1) st_nxt = ST_SHIFT;
        else                          st_nxt = ST_TRK;
      end
      ST_SHIFT: if (32'(tj_r) + 1 >= 32'(tcnt_r)) st_nxt = ST_TRK;
      ST_NEW: if (di_r >= dcnt_r) st_nxt = anyv_r ? ST_REP : ST_EMPTY;
      ST_REP: begin
        if (left_r == '0)                    st_nxt = ST_IDLE;
        else if (ti_r >= tcnt_r)             st_nxt = ST_IDLE;
        else if (!ov_r || out_ready)         st_nxt = ST_REP;
      end
      ST_REPW: if (out_ready) st_nxt = ST_IDLE;
      ST_EMPTY: st_nxt = ST_REPW;
      default: st_nxt = ST_IDLE;
    endcase
    if (st_r == ST_REP && st_nxt == ST_IDLE && ov_r) st_nxt = ST_REPW;
    if (st_r == ST_REP && st_nxt == ST_IDLE && !ov_r) st_nxt = ST_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RST; hit_r <= HIT_RST; max_r <= MAX_RST;
      vis_r <= VIS_RST; init_r <= INIT_RST;
      tcnt_r <= '0; dcnt_r <= '0; used_r <= '0; drop_r <= 1'b0;
      ov_r <= 1'b0; stall_r <= 1'b0; anyv_r <= 1'b0;
      ti_r <= '0; di_r <= '0; tj_r <= '0; hitf_r <= 1'b0;
      nvis_r <= '0; left_r <= '0;
    end else begin
      // one dead cycle after each stored detection
      stall_r <= (st_r == ST_IDLE) && in_valid && in_ready && (in_data.opcode == OP_DET);
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TOL:  tol_r  <= cfg_data;
          REG_HIT:  hit_r  <= cfg_data[5:0];
          REG_MAX:  max_r  <= cfg_data[5:0];
          REG_VIS:  vis_r  <= cfg_data[5:0];
          REG_INIT: init_r <= cfg_data[5:0];
          default: ;
        endcase
      end
      unique case (st_r)
        ST_IDLE: if (in_valid && in_ready) begin
          if (in_data.opcode == OP_DET) begin
            if (32'(dcnt_r) < MAX_DETECTIONS) begin
              dx_r[dcnt_r[DI-1:0]]  <= in_data.det_x & CMASK;
              dy_r[dcnt_r[DI-1:0]]  <= in_data.det_y & CMASK;
              dsz_r[dcnt_r[DI-1:0]] <= in_data.det_size;
              used_r[dcnt_r[DI-1:0]] <= 1'b0;
              dcnt_r <= dcnt_r + 1'b1;
            end else drop_r <= 1'b1;
          end else begin
            ti_r <= '0; anyv_r <= 1'b0; nvis_r <= '0;
          end
        end
        ST_TRK: begin
          di_r <= '0; hitf_r <= 1'b0;
          if (ti_r < tcnt_r) begin
            cx_r <= tx_r[ti_r[TI-1:0]]; cy_r <= ty_r[ti_r[TI-1:0]];
            cs_r <= ts_r[ti_r[TI-1:0]]; csc_r <= tsc_r[ti_r[TI-1:0]];
          end
        end
        ST_DET: if (di_r < dcnt_r) begin
          if (!used_r[di_r[DI-1:0]] && nx && ny) begin
            hitf_r <= 1'b1;
            csc_r <= (sum < {1'b0, max_r}) ? sum[5:0] : max_r;
            cx_r <= dx_r[di_r[DI-1:0]]; cy_r <= dy_r[di_r[DI-1:0]];
            cs_r <= dsz_r[di_r[DI-1:0]];
            used_r[di_r[DI-1:0]] <= 1'b1;
          end
          di_r <= di_r + 1'b1;
        end
        ST_TEND: begin
          if (!hitf_r && csc_r <= 6'd1) begin
            tj_r <= ti_r;
            if (32'(ti_r) + 1 >= 32'(tcnt_r)) tcnt_r <= tcnt_r - 1'b1;
          end else begin
            logic [5:0] ns;
            logic       v;
            ns = hitf_r ? csc_r : csc_r - 6'd1;
            v = (ns >= vis_r) && (32'(nvis_r) < 16);
            tx_r[ti_r[TI-1:0]] <= cx_r; ty_r[ti_r[TI-1:0]] <= cy_r;
            ts_r[ti_r[TI-1:0]] <= cs_r; tsc_r[ti_r[TI-1:0]] <= ns;
            tvis_r[ti_r[TI-1:0]] <= v;
            if (v) begin anyv_r <= 1'b1; nvis_r <= nvis_r + 1'b1; end
            ti_r <= ti_r + 1'b1;
            if (32'(ti_r) + 1 >= 32'(tcnt_r)) di_r <= '0;
          end
        end
        ST_SHIFT: begin
          if (32'(tj_r) + 1 < 32'(tcnt_r)) begin
            tx_r[tj_r[TI-1:0]]  <= tx_r[TI'(tj_r + 1'b1)];
            ty_r[tj_r[TI-1:0]]  <= ty_r[TI'(tj_r + 1'b1)];
            ts_r[tj_r[TI-1:0]]  <= ts_r[TI'(tj_r + 1'b1)];
            tsc_r[tj_r[TI-1:0]] <= tsc_r[TI'(tj_r + 1'b1)];
            tj_r <= tj_r + 1'b1;
            if (32'(tj_r) + 2 >= 32'(tcnt_r)) tcnt_r <= tcnt_r - 1'b1;
          end
          di_r <= '0;
        end
        ST_NEW: begin
          if (di_r < dcnt_r) begin
            if (!used_r[di_r[DI-1:0]]) begin
              if (32'(tcnt_r) < MAX_TRACKS) begin
                tx_r[tcnt_r[TI-1:0]]   <= dx_r[di_r[DI-1:0]];
                ty_r[tcnt_r[TI-1:0]]   <= dy_r[di_r[DI-1:0]];
                ts_r[tcnt_r[TI-1:0]]   <= dsz_r[di_r[DI-1:0]];
                tsc_r[tcnt_r[TI-1:0]]  <= init_r;
                tvis_r[tcnt_r[TI-1:0]] <= 1'b0;
                tcnt_r <= tcnt_r + 1'b1;
              end else drop_r <= 1'b1;
            end
            di_r <= di_r + 1'b1;
          end else begin
            ti_r <= '0; left_r <= nvis_r;
          end
        end
        ST_REP: begin
          if ((!ov_r || out_ready) && left_r != '0 && ti_r < tcnt_r) begin
            if (tvis_r[ti_r[TI-1:0]]) begin
              od_r.out_x <= tx_r[ti_r[TI-1:0]];
              od_r.out_y <= ty_r[ti_r[TI-1:0]];
              od_r.out_size <= ts_r[ti_r[TI-1:0]];
              od_r.out_score <= tsc_r[ti_r[TI-1:0]];
              od_r.any_visible <= 1'b1;
              od_r.is_last <= (left_r == TW'(1));
              od_r.overflow <= drop_r;
              ov_r <= 1'b1;
              left_r <= left_r - 1'b1;
            end else ov_r <= 1'b0;
            ti_r <= ti_r + 1'b1;
          end else if (ov_r && out_ready) ov_r <= 1'b0;
          if (left_r == '0 || ti_r >= tcnt_r) begin
            dcnt_r <= '0; used_r <= '0; drop_r <= 1'b0;
          end
        end
        ST_EMPTY: begin
          od_r <= '{out_x: 12'd0, out_y: 12'd0, out_size: 10'd0, out_score: 6'd0,
                    any_visible: 1'b0, is_last: 1'b1, overflow: drop_r};
          ov_r <= 1'b1;
          dcnt_r <= '0; used_r <= '0; drop_r <= 1'b0;
        end
        ST_REPW: if (out_ready) ov_r <= 1'b0;
        default: ;
      endcase
    end
  end
endmodule
